FILE: rtl/core/bptc_pkg.sv
// Shared widths, constants and types for the pressure/temperature compensation pipeline.
package bptc_pkg;

	localparam int RAW_W     = 24;
	localparam int CAL_W     = 16;
	localparam int TEMP_W    = 19;
	localparam int PRESS_W   = 23;
	localparam int CFG_IDX_W = 3;

	localparam int DT_W      = RAW_W + 1;
	localparam int PROD_W    = DT_W + CAL_W + 1;
	localparam int OFF_W     = 36;
	localparam int SENS_W    = 35;
	localparam int SENS_LO_W = 18;
	localparam int SENS_HI_W = SENS_W - SENS_LO_W;
	localparam int PP_W      = RAW_W + SENS_LO_W;
	localparam int FULL_W    = 60;

	localparam int C5_SHIFT       = 8;
	localparam int TEMP_SHIFT     = 23;
	localparam int OFF_DIV_SHIFT  = 7;
	localparam int SENS_DIV_SHIFT = 8;
	localparam int C2_SHIFT       = 16;
	localparam int C1_SHIFT       = 15;
	localparam int PROD_SHIFT     = 21;
	localparam int P_SHIFT        = 15;
	localparam int TEMP_BASE      = 2000;

	localparam int SCALED_W = FULL_W - PROD_SHIFT;
	localparam int DIFF_W   = SCALED_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_BASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMPCO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP_WORD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE    = 3'd5;

	typedef struct packed {
		logic [CAL_W-1:0] sens_base;
		logic [CAL_W-1:0] off_base;
		logic [CAL_W-1:0] sens_tempco;
		logic [CAL_W-1:0] off_tempco;
		logic [CAL_W-1:0] ref_temp_word;
		logic [CAL_W-1:0] temp_slope;
	} cfg_t;

	// coefficients handed from the first half of the pipe to the second
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} coef_t;

endpackage

FILE: rtl/core/bptc_if.sv
// Valid/ready channel interfaces for raw samples and compensated results.
interface bptc_in_if;
	import bptc_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;
	modport source(output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bptc_out_if;
	import bptc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [TEMP_W-1:0]  temperature_centi;
	logic signed [PRESS_W-1:0] pressure_centi;
	modport source(output valid, output temperature_centi, output pressure_centi, input ready);
	modport sink(input valid, input temperature_centi, input pressure_centi, output ready);
endinterface

FILE: rtl/core/baro_pressure_temp_compensation_unit.sv
// Data path: an accepted sample word is registered through stages s1 to s6 to become its result word.
// Throughput: one word per cycle while the output is not stalled; each of the six stages stalls only when its successor
// is full and stalled, so bubbles are squeezed out under backpressure.
// Multipliers: dT products in stage 2, D1*SENS split into two partial products in stage 4.
// Reset (arst_n low, asynchronous): all stage valid bits and calibration registers clear.
module baro_pressure_temp_compensation_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	bptc_in_if.sink                        sample,
	bptc_out_if.source                     result,
	input  logic                           cfg_we,
	input  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bptc_pkg::CAL_W-1:0]     cfg_data
);
	import bptc_pkg::*;

	localparam int DEPTH = 6;

	cfg_t  cfg;
	coef_t coef;
	logic  coef_valid, coef_ready;
	logic  out_valid_w;
	logic [2:0] occ_q;
	logic  acc_in, acc_out;

	bptc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bptc_coef_pipe u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.d1        (sample.raw_pressure),
		.d2        (sample.raw_temperature),
		.out_valid (coef_valid),
		.out_ready (coef_ready),
		.coef      (coef)
	);

	bptc_press_pipe u_press (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (coef_valid),
		.in_ready          (coef_ready),
		.coef              (coef),
		.out_valid         (out_valid_w),
		.out_ready         (result.ready),
		.temperature_centi (result.temperature_centi),
		.pressure_centi    (result.pressure_centi)
	);

	assign result.valid = out_valid_w;

	// words in flight, for checking only
	assign acc_in  = sample.valid && sample.ready;
	assign acc_out = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (acc_in && !acc_out) begin
			occ_q <= occ_q + 3'd1;
		end else if (acc_out && !acc_in) begin
			occ_q <= occ_q - 3'd1;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 3'(DEPTH))
		else $error("more words in flight than pipeline stages");

	a_out_has_src: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> occ_q != 3'd0)
		else $error("result word with no accepted sample behind it");

	a_ready_when_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> sample.ready)
		else $error("input stalled while output stage is empty");

endmodule

FILE: rtl/core/bptc_cfg_regs.sv
// Calibration word register file with a plain write port.
module bptc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bptc_pkg::CAL_W-1:0]     cfg_data,
	output bptc_pkg::cfg_t                 cfg
);
	import bptc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENS_BASE:     cfg_q.sens_base     <= cfg_data;
				REG_OFF_BASE:      cfg_q.off_base      <= cfg_data;
				REG_SENS_TEMPCO:   cfg_q.sens_tempco   <= cfg_data;
				REG_OFF_TEMPCO:    cfg_q.off_tempco    <= cfg_data;
				REG_REF_TEMP_WORD: cfg_q.ref_temp_word <= cfg_data;
				REG_TEMP_SLOPE:    cfg_q.temp_slope    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bptc_coef_pipe.sv
// Stages 1-3: dT, the three dT products, then TEMP, OFF and SENS.
module bptc_coef_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bptc_pkg::cfg_t             cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bptc_pkg::RAW_W-1:0] d1,
	input  logic [bptc_pkg::RAW_W-1:0] d2,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bptc_pkg::coef_t            coef
);
	import bptc_pkg::*;

	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	logic [RAW_W-1:0]         d1_s1, d1_s2, d1_s3;
	logic signed [DT_W-1:0]   dt_s1;
	logic signed [PROD_W-1:0] p6_s2, p4_s2, p3_s2;
	logic signed [TEMP_W-1:0] temp_s3;
	logic signed [OFF_W-1:0]  off_s3;
	logic signed [SENS_W-1:0] sens_s3;

	logic signed [DT_W-1:0]     dt_c;
	logic signed [CAL_W:0]      c6_c, c4_c, c3_c;
	logic signed [PROD_W-1:0]   p6_c, p4_c, p3_c;
	logic signed [PROD_W-1:0]   t_full, bias4, bias3, q4, q3;
	logic signed [OFF_W-1:0]    off_b, q4_t, off_c;
	logic signed [SENS_W-1:0]   sens_b, q3_t, sens_c;

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		dt_c = $signed({1'b0, d2}) - $signed({1'b0, cfg.ref_temp_word, {C5_SHIFT{1'b0}}});
		c6_c = $signed({1'b0, cfg.temp_slope});
		c4_c = $signed({1'b0, cfg.off_tempco});
		c3_c = $signed({1'b0, cfg.sens_tempco});
		p6_c = dt_s1 * c6_c;
		p4_c = dt_s1 * c4_c;
		p3_c = dt_s1 * c3_c;

		t_full = (p6_s2 >>> TEMP_SHIFT) + PROD_W'(TEMP_BASE);

		// divisions truncate toward zero: bias negatives before the shift
		bias4 = p4_s2[PROD_W-1] ? PROD_W'((1 << OFF_DIV_SHIFT) - 1) : '0;
		bias3 = p3_s2[PROD_W-1] ? PROD_W'((1 << SENS_DIV_SHIFT) - 1) : '0;
		q4    = (p4_s2 + bias4) >>> OFF_DIV_SHIFT;
		q3    = (p3_s2 + bias3) >>> SENS_DIV_SHIFT;
		q4_t  = q4[OFF_W-1:0];
		q3_t  = q3[SENS_W-1:0];
		off_b  = OFF_W'({cfg.off_base, {C2_SHIFT{1'b0}}});
		sens_b = SENS_W'({cfg.sens_base, {C1_SHIFT{1'b0}}});
		off_c  = off_b + q4_t;
		sens_c = sens_b + q3_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			d1_s1 <= d1;
			dt_s1 <= dt_c;
		end
		if (en2 && vld_s1) begin
			d1_s2 <= d1_s1;
			p6_s2 <= p6_c;
			p4_s2 <= p4_c;
			p3_s2 <= p3_c;
		end
		if (en3 && vld_s2) begin
			d1_s3   <= d1_s2;
			temp_s3 <= t_full[TEMP_W-1:0];
			off_s3  <= off_c;
			sens_s3 <= sens_c;
		end
	end

	assign out_valid = vld_s3;
	assign coef.d1   = d1_s3;
	assign coef.temp = temp_s3;
	assign coef.off  = off_s3;
	assign coef.sens = sens_s3;

endmodule

FILE: rtl/core/bptc_press_pipe.sv
// Stages 4-6: D1*SENS as two partial products, recombine and scale, subtract OFF and shift down.
module bptc_press_pipe (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bptc_pkg::coef_t                     coef,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bptc_pkg::TEMP_W-1:0]  temperature_centi,
	output logic signed [bptc_pkg::PRESS_W-1:0] pressure_centi
);
	import bptc_pkg::*;

	logic vld_s4, vld_s5, vld_s6;
	logic en4, en5, en6;

	logic signed [TEMP_W-1:0]   temp_s4, temp_s5, temp_s6;
	logic signed [OFF_W-1:0]    off_s4, off_s5;
	logic [PP_W-1:0]            pp_lo_s4;
	logic signed [PP_W-1:0]     pp_hi_s4;
	logic signed [SCALED_W-1:0] scaled_s5;
	logic signed [PRESS_W-1:0]  press_s6;

	logic [SENS_LO_W-1:0]        sens_lo;
	logic signed [SENS_HI_W-1:0] sens_hi;
	logic [PP_W-1:0]             pp_lo_c;
	logic signed [PP_W-1:0]      pp_hi_c;
	logic signed [FULL_W-1:0]    hi_ext, lo_ext, full_c, full_sh;
	logic signed [DIFF_W-1:0]    scaled_ext, off_ext, diff_c, p_c;

	assign en6      = !vld_s6 || out_ready;
	assign en5      = !vld_s5 || en6;
	assign en4      = !vld_s4 || en5;
	assign in_ready = en4;

	always_comb begin
		// signed SENS split into an unsigned low slice and a signed high slice
		sens_lo = coef.sens[SENS_LO_W-1:0];
		sens_hi = coef.sens[SENS_W-1:SENS_LO_W];
		pp_lo_c = coef.d1 * sens_lo;
		pp_hi_c = $signed({1'b0, coef.d1}) * sens_hi;

		hi_ext  = FULL_W'(pp_hi_s4);
		lo_ext  = FULL_W'(pp_lo_s4);
		full_c  = (hi_ext <<< SENS_LO_W) + lo_ext;
		full_sh = full_c >>> PROD_SHIFT;

		scaled_ext = DIFF_W'(scaled_s5);
		off_ext    = DIFF_W'(off_s5);
		diff_c     = scaled_ext - off_ext;
		p_c        = diff_c >>> P_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en4) vld_s4 <= in_valid;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && in_valid) begin
			temp_s4  <= coef.temp;
			off_s4   <= coef.off;
			pp_lo_s4 <= pp_lo_c;
			pp_hi_s4 <= pp_hi_c;
		end
		if (en5 && vld_s4) begin
			temp_s5   <= temp_s4;
			off_s5    <= off_s4;
			scaled_s5 <= full_sh[SCALED_W-1:0];
		end
		if (en6 && vld_s5) begin
			temp_s6  <= temp_s5;
			press_s6 <= p_c[PRESS_W-1:0];
		end
	end

	assign out_valid         = vld_s6;
	assign temperature_centi = temp_s6;
	assign pressure_centi    = press_s6;

endmodule

FILE: verif/baro_pressure_temp_compensation_unit_tb.sv
// Self-checking testbench for the pressure/temperature compensation pipeline.
module baro_pressure_temp_compensation_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bptc_pkg::*;

	localparam int LIMIT_CYCLES  = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 20;
	localparam int WORDS_PER_SET = 300;
	localparam int CAL_SETS      = 6;
	localparam int DIRECTED_ROWS = 36;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
	localparam logic [RAW_W-1:0]     RAW_MAX      = '1;
	localparam logic [CAL_W-1:0]     CAL_MAX      = '1;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0]  temperature_centi;
		logic signed [PRESS_W-1:0] pressure_centi;
	} reading_t;

	typedef struct {
		row_kind_t                 kind;
		logic [CFG_IDX_W-1:0]      index;
		logic [CAL_W-1:0]          data;
		logic [RAW_W-1:0]          d1;
		logic [RAW_W-1:0]          d2;
		bit                        fixed;
		logic signed [TEMP_W-1:0]  want_temp;
		logic signed [PRESS_W-1:0] want_press;
	} stim_row_t;

	// zero calibration first: SENS and OFF vanish, so the fixed-result words read 20.00 C and 0 pressure
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_CFG,  REG_UNUSED_6,      16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_UNUSED_7,      16'hA5A5, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'h0,      24'h0,      1'b1, 19'sd2000, 23'sd0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'hFFFFFF, 24'hFFFFFF, 1'b1, 19'sd2000, 23'sd0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'hFFFFFF, 24'h0,      1'b1, 19'sd2000, 23'sd0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'h0,      24'hFFFFFF, 1'b1, 19'sd2000, 23'sd0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'hAAAAAA, 24'h555555, 1'b1, 19'sd2000, 23'sd0},
		'{ROW_CFG,  REG_SENS_BASE,     16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_OFF_BASE,      16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_SENS_TEMPCO,   16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_OFF_TEMPCO,    16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_REF_TEMP_WORD, 16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_TEMP_SLOPE,    16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'hFFFFFF, 24'hFFFFFF, 1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'hFFFFFF, 24'h0,      1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'h555555, 24'hAAAAAA, 1'b0, '0,   '0},
		'{ROW_CFG,  REG_SENS_BASE,     16'd40127, 24'h0,     24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_OFF_BASE,      16'd36924, 24'h0,     24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_SENS_TEMPCO,   16'd23317, 24'h0,     24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_OFF_TEMPCO,    16'd23282, 24'h0,     24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_REF_TEMP_WORD, 16'd33464, 24'h0,     24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_TEMP_SLOPE,    16'd28312, 24'h0,     24'h0,      1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'd9085466, 24'd8569150, 1'b0, '0,  '0},
		// dT exactly zero, then dT = -1 where truncation and floor part ways
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'h800000, 24'h82B800, 1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'hFFFFFF, 24'h82B7FF, 1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'h0,      24'hFFFFFF, 1'b0, '0,   '0},
		'{ROW_CFG,  REG_SENS_BASE,     16'h0,    24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_OFF_BASE,      16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_SENS_TEMPCO,   16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_OFF_TEMPCO,    16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_REF_TEMP_WORD, 16'h0,    24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_CFG,  REG_TEMP_SLOPE,    16'hFFFF, 24'h0,      24'h0,      1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'h0,      24'hFFFFFF, 1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'hFFFFFF, 24'h0,      1'b0, '0,   '0},
		'{ROW_WORD, REG_SENS_BASE,     16'h0,    24'h123456, 24'h7FFFFF, 1'b0, '0,   '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0]     cfg_data;

	bptc_in_if  sample_ch ();
	bptc_out_if result_ch ();

	cfg_t     cal;
	reading_t expected_readings [$];
	int       mismatch_count = 0;
	int       cycle_count    = 0;
	int       send_idle_pct  = 0;
	int       recv_idle_pct  = 0;
	bit       hold_armed     = 1'b0;
	bit       hold_used      = 1'b0;
	int       hold_left      = 0;

	baro_pressure_temp_compensation_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// first-order compensation; '/' truncates toward zero, '>>>' floors
	function automatic reading_t compensate(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		longint   dt;
		longint   temp;
		longint   off;
		longint   sens;
		longint   p;
		reading_t r;
		dt   = longint'(d2) - (longint'(cal.ref_temp_word) << C5_SHIFT);
		temp = TEMP_BASE + ((dt * longint'(cal.temp_slope)) >>> TEMP_SHIFT);
		off  = (longint'(cal.off_base) << C2_SHIFT)
			+ (longint'(cal.off_tempco) * dt) / (longint'(1) << OFF_DIV_SHIFT);
		sens = (longint'(cal.sens_base) << C1_SHIFT)
			+ (longint'(cal.sens_tempco) * dt) / (longint'(1) << SENS_DIV_SHIFT);
		p    = (((longint'(d1) * sens) >>> PROD_SHIFT) - off) >>> P_SHIFT;
		r.temperature_centi = temp[TEMP_W-1:0];
		r.pressure_centi    = p[PRESS_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $time, msg);
		mismatch_count++;
	endtask

	// result side: check each accepted word, then pick ready for the next edge
	always @(posedge clk) begin
		reading_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (expected_readings.size() == 0) begin
				report_mismatch($sformatf("unexpected result word temp=%0d press=%0d",
					result_ch.temperature_centi, result_ch.pressure_centi));
			end else begin
				want = expected_readings.pop_front();
				if (result_ch.temperature_centi !== want.temperature_centi)
					report_mismatch($sformatf("temperature_centi got %0d want %0d",
						result_ch.temperature_centi, want.temperature_centi));
				if (result_ch.pressure_centi !== want.pressure_centi)
					report_mismatch($sformatf("pressure_centi got %0d want %0d",
						result_ch.pressure_centi, want.pressure_centi));
			end
		end
		if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_word(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
		input bit fixed = 1'b0, input reading_t want = '0);
		if ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.raw_pressure    <= d1;
		sample_ch.raw_temperature <= d2;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		expected_readings.push_back(fixed ? want : compensate(d1, d2));
	endtask

	task automatic stop_sending();
		sample_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data,
		input bit last);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_SENS_BASE:     cal.sens_base     = data;
			REG_OFF_BASE:      cal.off_base      = data;
			REG_SENS_TEMPCO:   cal.sens_tempco   = data;
			REG_OFF_TEMPCO:    cal.off_tempco    = data;
			REG_REF_TEMP_WORD: cal.ref_temp_word = data;
			REG_TEMP_SLOPE:    cal.temp_slope    = data;
			default: ;
		endcase
		if (last)
			cfg_we <= 1'b0;
	endtask

	task automatic load_calibration(input cfg_t c);
		// out-of-range index first; it must leave the calibration alone
		write_reg($urandom_range(1) ? REG_UNUSED_6 : REG_UNUSED_7, CAL_W'($urandom), 1'b0);
		write_reg(REG_SENS_BASE,     c.sens_base,     1'b0);
		write_reg(REG_OFF_BASE,      c.off_base,      1'b0);
		write_reg(REG_SENS_TEMPCO,   c.sens_tempco,   1'b0);
		write_reg(REG_OFF_TEMPCO,    c.off_tempco,    1'b0);
		write_reg(REG_REF_TEMP_WORD, c.ref_temp_word, 1'b0);
		write_reg(REG_TEMP_SLOPE,    c.temp_slope,    1'b1);
	endtask

	initial begin
		cfg_t             c;
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
		longint           near;
		int               pick;
		reading_t         want;
		arst_n                    <= 1'b0;
		cfg_we                    <= 1'b0;
		cfg_index                 <= '0;
		cfg_data                  <= '0;
		sample_ch.valid           <= 1'b0;
		sample_ch.raw_pressure    <= '0;
		sample_ch.raw_temperature <= '0;
		cal = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 53;
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				if (i == 0 || directed_rows[i-1].kind != ROW_CFG) begin
					stop_sending();
					wait_drained();
				end
				write_reg(directed_rows[i].index, directed_rows[i].data,
					i == DIRECTED_ROWS - 1 || directed_rows[i+1].kind != ROW_CFG);
			end else begin
				want.temperature_centi = directed_rows[i].want_temp;
				want.pressure_centi    = directed_rows[i].want_press;
				send_word(directed_rows[i].d1, directed_rows[i].d2,
					directed_rows[i].fixed, want);
			end
		end
		stop_sending();
		wait_drained();

		for (int s = 0; s < CAL_SETS; s++) begin
			case (s / 2)
				0: begin send_idle_pct = 21; recv_idle_pct = 53; end
				1: begin send_idle_pct = 53; recv_idle_pct = 21; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int k = 0; k < 6; k++) begin
				case (s)
					0: c[k*CAL_W +: CAL_W] = CAL_MAX;
					2: c[k*CAL_W +: CAL_W] = '0;
					3: c[k*CAL_W +: CAL_W] = CAL_W'($urandom_range(16'hFFFF, 16'h6000));
					4: begin
						pick = $urandom_range(2);
						c[k*CAL_W +: CAL_W] = (pick == 0) ? '0 : (pick == 1) ? CAL_MAX
							: CAL_W'($urandom);
					end
					default: c[k*CAL_W +: CAL_W] = CAL_W'($urandom);
				endcase
			end
			load_calibration(c);
			// long output stall with the input still pushing, so the pipe backs up
			if (s == 4)
				hold_armed = 1'b1;
			for (int n = 0; n < WORDS_PER_SET; n++) begin
				pick = $urandom_range(9);
				d1 = (pick == 0) ? '0 : (pick == 1) ? RAW_MAX : RAW_W'($urandom);
				pick = $urandom_range(19);
				if (pick < 10) begin
					d2 = (pick == 0) ? '0 : (pick == 1) ? RAW_MAX : RAW_W'($urandom);
				end else begin
					// readings near the reference temperature, as a real sensor gives
					near = (longint'(cal.ref_temp_word) << C5_SHIFT)
						+ longint'($urandom_range(131072)) - 65536;
					if (near < 0)
						near = 0;
					if (near > longint'(RAW_MAX))
						near = longint'(RAW_MAX);
					d2 = near[RAW_W-1:0];
				end
				send_word(d1, d2);
			end
			stop_sending();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/bptc_pkg.sv
rtl/core/bptc_if.sv
rtl/core/bptc_cfg_regs.sv
rtl/core/bptc_coef_pipe.sv
rtl/core/bptc_press_pipe.sv
rtl/core/baro_pressure_temp_compensation_unit.sv
verif/baro_pressure_temp_compensation_unit_tb.sv
